// ----- sv/lcts_pkg.sv -----
package lcts_pkg;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TARE   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CAL_VALID = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_THR  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MEAN_THR  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_MS   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COOL_MS   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ATT   = 3'd5;

  localparam int NEAR_THR_BITS = 15;
  localparam int MEAN_THR_BITS = 18;
  localparam int MS_CFG_BITS   = 16;
  localparam int ATT_BITS      = 3;
  localparam int TS_BITS       = 32;

  localparam int BAL_BITS = 16;
  localparam logic [BAL_BITS-1:0] BAL_POS_SAT = 16'h7FFF;
  localparam logic [BAL_BITS-1:0] BAL_NEG_SAT = 16'h8000;

  typedef struct packed {
    logic       load;
    logic [1:0] op;
    logic       have_raw;
  } lcts_lane_ctl_t;

endpackage

// ----- sv/lcts_lane.sv -----
module lcts_lane
  import lcts_pkg::*;
#(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lcts_lane_ctl_t                 ctl,
  input  logic signed [WEIGHT_BITS-1:0]  raw,
  input  logic [NEAR_THR_BITS-1:0]       near_thr,
  output logic signed [WEIGHT_BITS:0]    net,
  output logic                           near,
  output logic                           tare_nz
);

  localparam int NB = (WEIGHT_BITS + 1 > NEAR_THR_BITS + 1) ? WEIGHT_BITS + 1 : NEAR_THR_BITS + 1;

  logic signed [WEIGHT_BITS-1:0] tare_r, tare_nxt;
  logic signed [WEIGHT_BITS-1:0] last_raw_r, last_raw_nxt;
  logic signed [WEIGHT_BITS:0]   net_r, net_nxt;

  always_comb begin
    tare_nxt     = tare_r;
    last_raw_nxt = last_raw_r;
    net_nxt      = net_r;
    if (ctl.load) begin
      net_nxt = '0;
      case (ctl.op)
        OP_SAMPLE: begin
          last_raw_nxt = raw;
          net_nxt      = (WEIGHT_BITS + 1)'(raw) - (WEIGHT_BITS + 1)'(tare_r);
        end
        OP_TARE: begin
          if (ctl.have_raw) begin
            tare_nxt = last_raw_r;
          end
        end
        OP_CLEAR: begin
          tare_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tare_r     <= '0;
      last_raw_r <= '0;
      net_r      <= '0;
    end else begin
      tare_r     <= tare_nxt;
      last_raw_r <= last_raw_nxt;
      net_r      <= net_nxt;
    end
  end

  assign net     = net_r;
  assign near    = NB'(net_r) < $signed(NB'(near_thr));
  assign tare_nz = |tare_r;

endmodule

// ----- sv/lcts_div.sv -----
module lcts_div
  import lcts_pkg::*;
#(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [WEIGHT_BITS+2:0] num,
  input  logic signed [WEIGHT_BITS+2:0] den,
  output logic                          busy,
  output logic [BAL_BITS-1:0]           quo
);

  localparam int DB = WEIGHT_BITS + 3;
  localparam int RB = WEIGHT_BITS + 4;

  logic [RB-1:0]       rem_r, den_r;
  logic [BAL_BITS-1:0] q_r;
  logic [4:0]          cnt_r;
  logic                busy_r, neg_r, sat_r, zero_r;

  logic [DB-1:0] mag;
  logic [RB-1:0] den_u, diff;
  logic          ge;

  assign mag   = num[DB-1] ? DB'(-num) : DB'(num);
  assign den_u = RB'($unsigned(den));
  assign ge    = rem_r >= den_r;
  assign diff  = ge ? rem_r - den_r : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      zero_r <= 1'b1;
      sat_r  <= 1'b0;
      neg_r  <= 1'b0;
    end else if (start) begin
      neg_r  <= num[DB-1];
      den_r  <= den_u;
      rem_r  <= RB'(mag);
      q_r    <= '0;
      cnt_r  <= 5'd16;
      zero_r <= den <= $signed(DB'(1));
      sat_r  <= RB'(mag) >= (den_u << 1);
      busy_r <= (den > $signed(DB'(1))) && (RB'(mag) < (den_u << 1));
    end else if (busy_r) begin
      rem_r  <= diff << 1;
      q_r    <= {q_r[BAL_BITS-2:0], ge};
      cnt_r  <= cnt_r - 5'd1;
      busy_r <= cnt_r != 5'd1;
    end
  end

  always_comb begin
    if (zero_r) begin
      quo = '0;
    end else if (sat_r) begin
      quo = neg_r ? BAL_NEG_SAT : BAL_POS_SAT;
    end else if (neg_r) begin
      quo = (q_r > BAL_NEG_SAT) ? BAL_NEG_SAT : -q_r;
    end else begin
      quo = q_r[BAL_BITS-1] ? BAL_POS_SAT : q_r;
    end
  end

  assign busy = busy_r;

endmodule

// ----- sv/load_cell_tare_stuck_monitor_core.sv -----
// Channel | Dir | Handshake                  | Payload
// in_     | in  | in_tvalid / in_tready      | tdata: corners, timestamp; tuser: opcode
// out_    | out | out_tvalid / out_tready    | tdata: nets, total, balance, status
// cfg_    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One request at a time, accept to accept: lane, merge, 16 divider steps, output
// load, idle; no divider steps if neither quotient needs dividing (zero, saturated).
// A request is taken while the previous result still waits in the output register.
// rst_n is synchronous, active low; all but divider datapath registers get defaults.
// out_tready low holds the result; a finished division then waits for the slot.
module load_cell_tare_stuck_monitor_core
  import lcts_pkg::*;
#(
  parameter int WEIGHT_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // tr, br, tl, bl corners (WEIGHT_BITS each), timestamp_ms (32)
  input  logic [((4*WEIGHT_BITS+TS_BITS+7)/8)*8-1:0]   in_tdata,
  // opcode
  input  logic [1:0]                                   in_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // net tr, br, tl, bl, net_total, balance_x, balance_y,
  // tare_active, recovering, attempt_count, request_reinit
  output logic [((5*WEIGHT_BITS+7+2*BAL_BITS+6+7)/8)*8-1:0] out_tdata,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]                      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                     cfg_data
);

  localparam int NET_BITS = WEIGHT_BITS + 1;
  localparam int TOT_BITS = WEIGHT_BITS + 3;
  localparam int OUT_RAW  = 4 * NET_BITS + TOT_BITS + 2 * BAL_BITS + 6;
  localparam int OUT_TW   = ((OUT_RAW + 7) / 8) * 8;
  localparam int CB       = (TOT_BITS > MEAN_THR_BITS + 1) ? TOT_BITS : MEAN_THR_BITS + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LANE = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic                     cal_r;
  logic [NEAR_THR_BITS-1:0] near_thr_r;
  logic [MEAN_THR_BITS-1:0] mean_thr_r;
  logic [MS_CFG_BITS-1:0]   hold_r, cool_r;
  logic [ATT_BITS-1:0]      max_att_r;

  logic                 have_raw_r;
  logic [1:0]           op_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 tare_act_r;

  logic signed [TOT_BITS-1:0] total_r, numx_r, numy_r;
  logic                       stuck_r;

  logic                 stuck_timing_r;
  logic [TIME_BITS-1:0] stuck_start_r, last_rec_r;
  logic [ATT_BITS-1:0]  attempts_r;
  logic                 recovering_r, reinit_r;

  logic                out_valid_r;
  logic [OUT_TW-1:0]   out_tdata_r;

  logic accept, load_out, any_tare;
  lcts_lane_ctl_t lane_ctl;

  logic signed [WEIGHT_BITS-1:0] raw [4];
  logic signed [NET_BITS-1:0]    net [4];
  logic [3:0]                    near, tare_nz;

  logic                  busy_x, busy_y;
  logic [BAL_BITS-1:0]   bal_x, bal_y;

  logic signed [TOT_BITS-1:0] total_c, numx_c, numy_c;
  logic                       stuck_c;
  logic [TIME_BITS-1:0]       since_start, since_rec;

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = rst_n;
  assign any_tare  = |tare_nz;

  assign lane_ctl.load     = accept;
  assign lane_ctl.op       = in_tuser;
  assign lane_ctl.have_raw = have_raw_r;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign raw[i] = in_tdata[i*WEIGHT_BITS +: WEIGHT_BITS];
    lcts_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .raw      (raw[i]),
      .near_thr (near_thr_r),
      .net      (net[i]),
      .near     (near[i]),
      .tare_nz  (tare_nz[i])
    );
  end

  // lanes: 0 top right, 1 bottom right, 2 top left, 3 bottom left
  assign total_c = TOT_BITS'(net[0]) + TOT_BITS'(net[1]) + TOT_BITS'(net[2])
                 + TOT_BITS'(net[3]);
  assign numx_c  = (TOT_BITS'(net[0]) + TOT_BITS'(net[1]))
                 - (TOT_BITS'(net[2]) + TOT_BITS'(net[3]));
  assign numy_c  = (TOT_BITS'(net[0]) + TOT_BITS'(net[2]))
                 - (TOT_BITS'(net[1]) + TOT_BITS'(net[3]));
  assign stuck_c = cal_r && ($countones(near) >= 3)
                 && (CB'(total_c) >= $signed(CB'(mean_thr_r)));

  assign since_start = now_r - stuck_start_r;
  assign since_rec   = now_r - last_rec_r;

  lcts_div #(.WEIGHT_BITS(WEIGHT_BITS)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SUM),
    .num   (numx_r),
    .den   (total_r),
    .busy  (busy_x),
    .quo   (bal_x)
  );

  lcts_div #(.WEIGHT_BITS(WEIGHT_BITS)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SUM),
    .num   (numy_r),
    .den   (total_r),
    .busy  (busy_y),
    .quo   (bal_y)
  );

  assign load_out = (state_r == S_DIV) && !busy_x && !busy_y
                 && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_LANE;
      S_LANE: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DIV;
      S_DIV:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cal_r      <= 1'b0;
      near_thr_r <= NEAR_THR_BITS'(30);
      mean_thr_r <= MEAN_THR_BITS'(300);
      hold_r     <= MS_CFG_BITS'(1500);
      cool_r     <= MS_CFG_BITS'(4000);
      max_att_r  <= ATT_BITS'(4);
      have_raw_r <= 1'b0;
      op_r       <= OP_SAMPLE;
      now_r      <= '0;
      tare_act_r <= 1'b0;
      total_r    <= '0;
      numx_r     <= '0;
      numy_r     <= '0;
      stuck_r    <= 1'b0;
      stuck_timing_r <= 1'b0;
      stuck_start_r  <= '0;
      last_rec_r     <= '0;
      attempts_r     <= '0;
      recovering_r   <= 1'b0;
      reinit_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      out_tdata_r    <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_CAL_VALID: cal_r      <= cfg_data[0];
          CFG_NEAR_THR:  near_thr_r <= cfg_data[NEAR_THR_BITS-1:0];
          CFG_MEAN_THR:  mean_thr_r <= cfg_data[MEAN_THR_BITS-1:0];
          CFG_HOLD_MS:   hold_r     <= cfg_data[MS_CFG_BITS-1:0];
          CFG_COOL_MS:   cool_r     <= cfg_data[MS_CFG_BITS-1:0];
          CFG_MAX_ATT:   max_att_r  <= cfg_data[ATT_BITS-1:0];
          default: begin
          end
        endcase
      end

      if (accept) begin
        op_r  <= in_tuser;
        now_r <= TIME_BITS'(in_tdata[4*WEIGHT_BITS +: TS_BITS]);
        case (in_tuser)
          OP_SAMPLE: begin
            have_raw_r <= 1'b1;
            tare_act_r <= any_tare;
          end
          OP_TARE:  tare_act_r <= have_raw_r || any_tare;
          OP_CLEAR: tare_act_r <= 1'b0;
          default:  tare_act_r <= any_tare;
        endcase
      end

      if (state_r == S_LANE) begin
        total_r <= total_c;
        numx_r  <= numx_c;
        numy_r  <= numy_c;
        stuck_r <= stuck_c;
      end

      if (state_r == S_SUM) begin
        reinit_r <= 1'b0;
        if (op_r == OP_SAMPLE) begin
          if (!stuck_r) begin
            stuck_timing_r <= 1'b0;
            stuck_start_r  <= '0;
            recovering_r   <= 1'b0;
            attempts_r     <= '0;
          end else if (!stuck_timing_r) begin
            stuck_timing_r <= 1'b1;
            stuck_start_r  <= now_r;
          end else if (since_start >= TIME_BITS'(hold_r)
                       && since_rec >= TIME_BITS'(cool_r)) begin
            recovering_r <= 1'b1;
            if (attempts_r < max_att_r) begin
              attempts_r     <= attempts_r + ATT_BITS'(1);
              last_rec_r     <= now_r;
              stuck_timing_r <= 1'b0;
              reinit_r       <= 1'b1;
            end
          end
        end
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
        out_tdata_r <= OUT_TW'({reinit_r, attempts_r, recovering_r, tare_act_r,
                                bal_y, bal_x, total_r, net[3], net[2], net[1], net[0]});
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- sim/load_cell_tare_stuck_monitor_core_tb.sv -----
`timescale 1ns / 100ps

module load_cell_tare_stuck_monitor_core_tb;
  import lcts_pkg::*;

  localparam int IN_W           = ((4*16+TS_BITS+7)/8)*8;
  localparam int OUT_W          = ((5*16+7+2*BAL_BITS+6+7)/8)*8;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [31:0]      ts;
    logic [3:0][15:0] raw;   // [0] tr, [1] br, [2] tl, [3] bl
  } lc_sample_t;

  typedef struct packed {
    logic [1:0] op;
    lc_sample_t d;
  } lc_req_t;

  typedef struct packed {
    logic [2:0]       pad;
    logic             reinit;
    logic [2:0]       attempts;
    logic             recovering;
    logic             tare_active;
    logic [15:0]      bal_y;
    logic [15:0]      bal_x;
    logic [18:0]      total;
    logic [3:0][16:0] net;
  } lc_readout_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata = '0;
  logic [1:0]               in_tuser = OP_SAMPLE;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_W-1:0]         out_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_CAL_VALID;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // predictor configuration and state
  logic                     cal_valid = 1'b0;
  logic [14:0]              near_thr = 15'd30;
  logic [17:0]              mean_thr = 18'd300;
  logic [15:0]              hold_ms = 16'd1500;
  logic [15:0]              cool_ms = 16'd4000;
  logic [2:0]               max_att = 3'd4;
  logic signed [15:0]       tare_w [4] = '{default: '0};
  logic signed [15:0]       last_w [4] = '{default: '0};
  logic                     seen_raw = 1'b0;
  logic                     timing_on = 1'b0;
  logic [31:0]              stuck_t0 = '0;
  logic [31:0]              last_reinit_t = '0;
  logic [2:0]               attempts = '0;
  logic                     recov_flag = 1'b0;

  // stimulus-side shadow of the tare, used to aim net values
  int                       gen_tare [4] = '{default: 0};
  int                       gen_last [4] = '{default: 0};
  bit                       gen_have = 1'b0;
  logic [31:0]              gen_now = '0;

  lc_req_t                  pending_requests [$];
  lc_readout_t              expected_readouts [$];
  lc_req_t                  cur_req;
  lc_readout_t              got, want;
  bit                       idle_on = 1'b1;
  int                       hold_req = 0;
  int                       rx_hold = 0;
  int                       rx_stall = 0;
  int                       tx_gap = 0;
  int                       quiet_cycles = 0;
  int                       n_pushed = 0;
  int                       n_requests = 0;
  int                       n_readouts = 0;
  int                       n_reinit = 0;
  int                       n_recov = 0;
  int                       n_errors = 0;

  load_cell_tare_stuck_monitor_core DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] q15_frac(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag << 15) / den;
    if (num < 0) return (q > 32768) ? BAL_NEG_SAT : 16'(-q);
    return (q > 32767) ? BAL_POS_SAT : 16'(q);
  endfunction

  function automatic logic tare_loaded();
    return tare_w[0] != 0 || tare_w[1] != 0 || tare_w[2] != 0 || tare_w[3] != 0;
  endfunction

  function automatic lc_readout_t weigh_request(lc_req_t rq);
    lc_readout_t r;
    longint      net [4];
    longint      total;
    int          near_cnt;
    logic        stuck;
    logic [31:0] since_start, since_reinit;
    r = '0;
    total = 0;
    near_cnt = 0;
    case (rq.op)
      OP_SAMPLE: begin
        for (int i = 0; i < 4; i++) begin
          last_w[i] = $signed(rq.d.raw[i]);
          net[i] = longint'(last_w[i]) - longint'(tare_w[i]);
          total += net[i];
          r.net[i] = net[i][16:0];
          if (net[i] < longint'(near_thr)) near_cnt++;
        end
        seen_raw = 1'b1;
        r.total = total[18:0];
        if (total > 1) begin
          r.bal_x = q15_frac((net[0] + net[1]) - (net[2] + net[3]), total);
          r.bal_y = q15_frac((net[0] + net[2]) - (net[1] + net[3]), total);
        end
        r.tare_active = tare_loaded();
        stuck = cal_valid && near_cnt >= 3 && total >= longint'(mean_thr);
        since_start = rq.d.ts - stuck_t0;
        since_reinit = rq.d.ts - last_reinit_t;
        if (!stuck) begin
          timing_on = 1'b0;
          stuck_t0 = '0;
          recov_flag = 1'b0;
          attempts = '0;
        end else if (!timing_on) begin
          timing_on = 1'b1;
          stuck_t0 = rq.d.ts;
        end else if (since_start >= 32'(hold_ms) && since_reinit >= 32'(cool_ms)) begin
          recov_flag = 1'b1;
          if (attempts < max_att) begin
            attempts = attempts + 3'd1;
            last_reinit_t = rq.d.ts;
            timing_on = 1'b0;
            r.reinit = 1'b1;
          end
        end
      end
      OP_TARE: begin
        if (seen_raw) begin
          for (int i = 0; i < 4; i++) tare_w[i] = last_w[i];
          r.tare_active = 1'b1;
        end else begin
          r.tare_active = tare_loaded();
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < 4; i++) tare_w[i] = '0;
        r.tare_active = 1'b0;
      end
      default: r.tare_active = tare_loaded();
    endcase
    r.recovering = recov_flag;
    r.attempts = attempts;
    return r;
  endfunction

  task automatic report_bad(string what, longint got_v, longint want_v);
    n_errors++;
    if (n_errors <= 100)
      $display("[%0t] readout %0d: %s got 0x%0h expected 0x%0h",
               $time, n_readouts, what, got_v, want_v);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_readouts.push_back(weigh_request(cur_req));
        n_requests++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          cur_req = pending_requests.pop_front();
          in_tuser <= cur_req.op;
          in_tdata <= cur_req.d;
          in_tvalid <= 1'b1;
          tx_gap = idle_on ? pick_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        n_readouts++;
        if (got.reinit) n_reinit++;
        if (got.recovering) n_recov++;
        if (expected_readouts.size() == 0) begin
          report_bad("readout with no request pending", longint'(got.total), 0);
        end else begin
          want = expected_readouts.pop_front();
          for (int i = 0; i < 4; i++)
            if (got.net[i] !== want.net[i])
              report_bad($sformatf("net corner %0d", i), got.net[i], want.net[i]);
          if (got.total !== want.total) report_bad("net_total", got.total, want.total);
          if (got.bal_x !== want.bal_x) report_bad("balance_x", got.bal_x, want.bal_x);
          if (got.bal_y !== want.bal_y) report_bad("balance_y", got.bal_y, want.bal_y);
          if (got.tare_active !== want.tare_active)
            report_bad("tare_active", got.tare_active, want.tare_active);
          if (got.recovering !== want.recovering)
            report_bad("recovering", got.recovering, want.recovering);
          if (got.attempts !== want.attempts)
            report_bad("attempt_count", got.attempts, want.attempts);
          if (got.reinit !== want.reinit)
            report_bad("request_reinit", got.reinit, want.reinit);
        end
      end
      if (hold_req != 0) begin
        rx_hold = hold_req;
        hold_req = 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) rx_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CAL_VALID: cal_valid = val[0];
      CFG_NEAR_THR:  near_thr = val[14:0];
      CFG_MEAN_THR:  mean_thr = val[17:0];
      CFG_HOLD_MS:   hold_ms = val[15:0];
      CFG_COOL_MS:   cool_ms = val[15:0];
      CFG_MAX_ATT:   max_att = val[2:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (n_requests != n_pushed || expected_readouts.size() != 0);
  endtask

  function automatic void push_req(logic [1:0] op, int c0, int c1, int c2, int c3,
                                   logic [31:0] ts);
    lc_req_t rq;
    rq.op = op;
    rq.d.ts = ts;
    rq.d.raw[0] = c0[15:0];
    rq.d.raw[1] = c1[15:0];
    rq.d.raw[2] = c2[15:0];
    rq.d.raw[3] = c3[15:0];
    case (op)
      OP_SAMPLE: begin
        for (int i = 0; i < 4; i++) gen_last[i] = $signed(rq.d.raw[i]);
        gen_have = 1'b1;
      end
      OP_TARE: if (gen_have) gen_tare = gen_last;
      OP_CLEAR: gen_tare = '{default: 0};
      default: ;
    endcase
    pending_requests.push_back(rq);
    n_pushed++;
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // sample aimed at given net corner values under the current tare
  function automatic void push_net(int n0, int n1, int n2, int n3);
    push_req(OP_SAMPLE, clamp16(n0 + gen_tare[0]), clamp16(n1 + gen_tare[1]),
             clamp16(n2 + gen_tare[2]), clamp16(n3 + gen_tare[3]), gen_now);
  endfunction

  function automatic int wild_corner();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return int'($urandom_range(0, 200)) - 100;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int near_value();
    if ($urandom_range(0, 9) == 0) return int'(near_thr);
    return int'(near_thr) - 1 - int'($urandom_range(0, 60));
  endfunction

  function automatic void advance_clock();
    int unsigned span;
    int          r;
    span = (hold_ms + cool_ms) / 4 + 1;
    r = $urandom_range(0, 19);
    if (r < 15) gen_now += $urandom_range(0, span);
    else if (r < 18) gen_now += $urandom_range(0, 4 * span);
    else if (r == 18) gen_now = $urandom;
  endfunction

  // mostly stuck episodes with random content, some noise in between
  task automatic random_traffic(int n);
    int left, len, hot, kind;
    int v [4];
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(3, 40);
        hot = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
          kind = $urandom_range(0, 19);
          advance_clock();
          if (kind == 0) begin
            push_req($urandom_range(0, 1) ? OP_TARE : OP_CLEAR, wild_corner(),
                     wild_corner(), wild_corner(), wild_corner(), $urandom);
          end else if (kind == 1) begin
            push_net($urandom_range(0, 1000), $urandom_range(0, 1000),
                     $urandom_range(0, 1000), $urandom_range(0, 1000));
          end else begin
            for (int j = 0; j < 4; j++)
              v[j] = (j == hot) ? int'(mean_thr) + int'($urandom_range(0, 2000))
                                : near_value();
            push_net(v[0], v[1], v[2], v[3]);
          end
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          kind = $urandom_range(0, 9);
          advance_clock();
          push_req((kind < 6) ? OP_SAMPLE : ((kind < 8) ? OP_TARE : OP_CLEAR),
                   wild_corner(), wild_corner(), wild_corner(), wild_corner(),
                   (kind < 6) ? gen_now : 32'($urandom));
        end
      end
      left -= len;
    end
  endtask

  task automatic set_config(int cal, int near, int mean, int hold, int cool, int maxa);
    cfg_write(CFG_CAL_VALID, cal);
    cfg_write(CFG_NEAR_THR, near);
    cfg_write(CFG_MEAN_THR, mean);
    cfg_write(CFG_HOLD_MS, hold);
    cfg_write(CFG_COOL_MS, cool);
    cfg_write(CFG_MAX_ATT, maxa);
  endtask

  task automatic run_phase(int cal, int near, int mean, int hold, int cool, int maxa,
                           bit idle, int hold_off, int n);
    set_config(cal, near, mean, hold, cool, maxa);
    idle_on = idle;
    hold_req = hold_off;
    random_traffic(n);
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: tare, clear, totals near zero, saturation, extremes
    push_req(OP_TARE, 0, 0, 0, 0, 0);
    push_req(OP_CLEAR, 0, 0, 0, 0, 0);
    push_req(OP_SAMPLE, 0, 0, 0, 0, 0);
    push_req(OP_SAMPLE, 1, 0, 0, 0, 1);
    push_req(OP_SAMPLE, 2, 0, 0, 0, 2);
    push_req(OP_SAMPLE, 0, 0, 2, 0, 3);
    push_req(OP_SAMPLE, 0, 2, 0, 0, 4);
    push_req(OP_SAMPLE, 5, -3, 7, 1, 5);
    push_req(OP_SAMPLE, -32768, -32768, -32768, -32768, 6);
    push_req(OP_TARE, 0, 0, 0, 0, 0);
    push_req(OP_SAMPLE, 32767, 32767, 32767, 32767, 7);
    push_req(OP_SAMPLE, -32768, 32767, 100, -5, 8);
    push_req(OP_CLEAR, 0, 0, 0, 0, 0);
    push_req(OP_SAMPLE, 0, 0, 0, 0, 9);
    push_req(OP_TARE, 0, 0, 0, 0, 0);
    push_req(OP_SAMPLE, 32767, -32768, 0, 0, 32'hFFFF_FFFF);
    wait_idle();

    // stuck monitor: hold, cooldown, attempt limit, release, time wrap
    set_config(1, 30, 300, 10, 20, 2);
    push_req(OP_CLEAR, 0, 0, 0, 0, 0);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 100);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 105);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 110);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 111);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 125);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 131);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 132);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 160);
    push_req(OP_SAMPLE, 500, 0, 10, -5, 170);
    push_req(OP_SAMPLE, 0, 0, 0, 0, 171);
    push_req(OP_SAMPLE, 0, 20, 400, 3, 32'hFFFF_FFF8);
    push_req(OP_SAMPLE, 0, 20, 400, 3, 32'h0000_0004);
    gen_now = 32'h10;
    wait_idle();

    run_phase(1, 30, 300, 20, 50, 3, 1'b1, 0, 200);
    run_phase(1, 32767, 0, 0, 0, 7, 1'b1, 0, 180);
    run_phase(1, 0, 262143, 65535, 65535, 0, 1'b0, 0, 120);
    run_phase(0, 30, 300, 0, 0, 7, 1'b1, 0, 120);
    run_phase(1, 500, 1000, 100, 200, 1, 1'b0, 400, 180);
    run_phase(1, $urandom_range(1, 3000), $urandom_range(0, 5000), $urandom_range(0, 300),
              $urandom_range(0, 500), $urandom_range(0, 7), 1'b1, 0, 200);
    run_phase(1, 1, 1, 1, 65535, 5, 1'b1, 0, 120);

    repeat (50) @(posedge clk);
    if (expected_readouts.size() != 0)
      report_bad("readouts never delivered", expected_readouts.size(), 0);
    $display("covered %0d requests and %0d readouts over 9 register settings",
             n_requests, n_readouts);
    $display("re-init requests seen: %0d, readouts with recovering set: %0d",
             n_reinit, n_recov);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- load_cell_tare_stuck_monitor_core.f -----
sv/lcts_pkg.sv
sv/lcts_lane.sv
sv/lcts_div.sv
sv/load_cell_tare_stuck_monitor_core.sv
sim/load_cell_tare_stuck_monitor_core_tb.sv
